// File: rtl/refcount_page_allocator_defines.svh
// ---------------------------------------------------------------------------
// refcount page allocator assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef REFCOUNT_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNT_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// checked at every clock edge outside reset
`define RPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("refcount page allocator assertion failed");

// checked at every clock edge, reset included
`define RPA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("refcount page allocator assertion failed");

`else

`define RPA_ASSERT(lbl, prop)
`define RPA_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: rtl/rpa_pkg.sv
// ---------------------------------------------------------------------------
// rpa_pkg
// shared constants and types of the refcount page allocator
// ---------------------------------------------------------------------------
`default_nettype none

package rpa_pkg;

  // page table geometry
  localparam int NUM_PAGES  = 512;
  localparam int PAGE_BYTES = 4096;

  // field widths
  localparam int PAGE_W = 9;
  localparam int CNT_W  = 8;
  localparam int CMD_W  = 2;
  localparam int SIZE_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // free map: one bit per page, set while the page count is zero
  localparam int MAP_BITS  = 32;
  localparam int BIT_W     = $clog2(MAP_BITS);
  localparam int MAP_WORDS = NUM_PAGES / MAP_BITS;
  localparam int WORD_W    = PAGE_W - BIT_W;

  // stream widths, padded to whole bytes
  localparam int IN_W       = CMD_W + PAGE_W + SIZE_W;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = 1 + PAGE_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_SHARE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST = 2'd0,
    REG_LAST  = 2'd1,
    REG_RSVD  = 2'd2
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_RMW   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  // input item, last field (command) in the lowest bits
  typedef struct packed {
    logic [SIZE_W-1:0] size_bytes;
    logic [PAGE_W-1:0] page_index;
    logic [CMD_W-1:0]  command;
  } in_item_t;

  // result item, last field (ok) in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]  count_after;
    logic [PAGE_W-1:0] granted_page;
    logic              ok;
  } res_item_t;

  // outcome of a free map word search
  typedef struct packed {
    logic              found;
    logic [PAGE_W-1:0] page;
  } hit_t;

endpackage

`default_nettype wire

// File: rtl/rpa_find_first.sv
// ---------------------------------------------------------------------------
// rpa_find_first
// lowest allocatable free page within one free map word
// ---------------------------------------------------------------------------
`default_nettype none

module rpa_find_first
  import rpa_pkg::*;
(
  input  logic [MAP_BITS-1:0] map_word_i,
  input  logic [WORD_W-1:0]   word_idx_i,
  input  logic [PAGE_W-1:0]   first_page_i,
  input  logic [PAGE_W-1:0]   last_page_i,
  input  logic [PAGE_W-1:0]   rsvd_page_i,
  output hit_t                hit_o
);

  logic [MAP_BITS-1:0] avail;

  // free and inside the window, reserved page excluded
  always_comb begin
    logic [PAGE_W-1:0] pg;
    avail = '0;
    for (int b = 0; b < MAP_BITS; b++) begin
      pg = {word_idx_i, BIT_W'(b)};
      avail[b] = map_word_i[b] && (pg >= first_page_i) && (pg <= last_page_i) &&
                 (pg != rsvd_page_i);
    end
  end

  // priority encoder, lowest bit wins
  always_comb begin
    hit_o = '0;
    for (int b = MAP_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        hit_o.found = 1'b1;
        hit_o.page  = {word_idx_i, BIT_W'(b)};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/refcount_page_allocator.sv
// ---------------------------------------------------------------------------
// refcount_page_allocator
// first-fit page allocator with a reference count per page
// ---------------------------------------------------------------------------
// After reset the block sweeps both memories (at one page a
// cycle) and takes no item until done; configuration writes are taken at
// any time. Counts live in a 512 x 8 memory, and a 16 x 32 free map holds
// one bit per page that is set while the count is zero. Free, share and the
// unused command pass from acceptance through a read of both memories,
// a write back (free and share only) and the hand over of the result
// before the next acceptance. Allocate reads one free map word a cycle
// from the word of first_page up to the word of last_page and stops at
// the first word with a hit; a too large request or an empty window
// skips the search. One item is in work at a time; a new one is
// taken while the previous result still waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "refcount_page_allocator_defines.svh"

module refcount_page_allocator
  import rpa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [PAGE_W-1:0]      cfg_wdata_i,
  // command stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // command, page_index, size_bytes
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // ok, granted_page, count_after
);

  // memories
  logic [CNT_W-1:0]    cnt_mem [NUM_PAGES];
  logic [MAP_BITS-1:0] map_mem [MAP_WORDS];

  // control and payload state
  state_e            state_q, state_d;
  logic [PAGE_W-1:0] clr_q, clr_d;
  logic [PAGE_W-1:0] first_q, last_q, rsvd_q;
  logic              m_valid_q, m_valid_d;
  res_item_t         m_data_q;
  res_item_t         rslt_q, rslt_d;
  cmd_e              cmd_q, cmd_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [WORD_W-1:0] word_q, word_d;

  // memory ports
  logic                cnt_we;
  logic [PAGE_W-1:0]   cnt_waddr;
  logic [CNT_W-1:0]    cnt_wdata;
  logic [CNT_W-1:0]    cnt_rdata_q;
  logic                map_we;
  logic [WORD_W-1:0]   map_waddr;
  logic [MAP_BITS-1:0] map_wdata;
  logic [MAP_BITS-1:0] map_rdata_q;

  in_item_t          in_item;
  hit_t              hit;
  logic              accept;
  logic              out_load;
  logic              in_range;
  logic              rmw_ok;
  logic [CNT_W-1:0]  rmw_cnt;
  logic [WORD_W-1:0] last_word;

  assign in_item       = in_item_t'(s_axis_tdata[IN_W-1:0]);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last_word     = last_q[PAGE_W-1:BIT_W];
  assign in_range      = (32'(page_q) < NUM_PAGES);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= PAGE_W'(1);
      last_q  <= PAGE_W'(511);
      rsvd_q  <= PAGE_W'(184);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIRST: first_q <= cfg_wdata_i;
        REG_LAST:  last_q  <= cfg_wdata_i;
        REG_RSVD:  rsvd_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // count and free map memories, registered reads
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[in_item.page_index];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rdata_q <= map_mem[word_d];
  end

  // search of the current free map word
  rpa_find_first u_find (
    .map_word_i   (map_rdata_q),
    .word_idx_i   (word_q),
    .first_page_i (first_q),
    .last_page_i  (last_q),
    .rsvd_page_i  (rsvd_q),
    .hit_o        (hit)
  );

  // free and share update of the addressed count
  always_comb begin
    rmw_ok  = 1'b0;
    rmw_cnt = cnt_rdata_q;
    case (cmd_q)
      CMD_FREE: begin
        if (page_q != '0 && cnt_rdata_q != '0) begin
          rmw_ok  = 1'b1;
          rmw_cnt = cnt_rdata_q - CNT_W'(1);
        end
      end
      CMD_SHARE: begin
        if (cnt_rdata_q != CNT_MAX) begin
          rmw_ok  = 1'b1;
          rmw_cnt = cnt_rdata_q + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cmd_d     = cmd_q;
    page_d    = page_q;
    word_d    = word_q;
    rslt_d    = rslt_q;
    cnt_we    = 1'b0;
    cnt_waddr = page_q;
    cnt_wdata = rmw_cnt;
    map_we    = 1'b0;
    map_waddr = page_q[PAGE_W-1:BIT_W];
    map_wdata = map_rdata_q;
    map_wdata[page_q[BIT_W-1:0]] = (rmw_cnt == '0);
    out_load  = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        map_we    = 1'b1;
        map_waddr = clr_q[PAGE_W-1:BIT_W];
        map_wdata = '1;
        clr_d     = clr_q + PAGE_W'(1);
        if (clr_q == PAGE_W'(NUM_PAGES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_e'(in_item.command);
          page_d = in_item.page_index;
          rslt_d = '{count_after: '0, granted_page: '0, ok: 1'b0};
          if (in_item.command == CMD_ALLOC) begin
            word_d = first_q[PAGE_W-1:BIT_W];
            if ((32'(in_item.size_bytes) > PAGE_BYTES) || (first_q > last_q)) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end else begin
            word_d  = in_item.page_index[PAGE_W-1:BIT_W];
            state_d = ST_RMW;
          end
        end
      end

      // one free map word per cycle
      ST_SCAN: begin
        if (hit.found) begin
          cnt_we    = 1'b1;
          cnt_waddr = hit.page;
          cnt_wdata = CNT_W'(1);
          map_we    = 1'b1;
          map_waddr = word_q;
          map_wdata = map_rdata_q;
          map_wdata[hit.page[BIT_W-1:0]] = 1'b0;
          rslt_d    = '{count_after: CNT_W'(1), granted_page: hit.page, ok: 1'b1};
          state_d   = ST_DONE;
        end else if (word_q == last_word) begin
          state_d = ST_DONE;
        end else begin
          word_d = word_q + WORD_W'(1);
        end
      end

      // write back count and free bit for free and share
      ST_RMW: begin
        if (in_range && (cmd_q == CMD_FREE || cmd_q == CMD_SHARE)) begin
          cnt_we = 1'b1;
          map_we = 1'b1;
        end
        rslt_d = '{count_after: in_range ? rmw_cnt : '0,
                   granted_page: page_q,
                   ok: rmw_ok && in_range};
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_CLEAR;
    endcase
  end

  // output valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    page_q <= page_d;
    word_q <= word_d;
    rslt_q <= rslt_d;
    if (out_load) begin
      m_data_q <= rslt_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - OUT_W)'(0), m_data_q};

  // assertions
  `RPA_ASSERT(a_one_item_in_work, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `RPA_ASSERT(a_grant_in_window, (state_q == ST_SCAN && hit.found) |-> (hit.page >= first_q && hit.page <= last_q && hit.page != rsvd_q))
  `RPA_ASSERT(a_no_result_overwrite, out_load |-> (!m_valid_q || m_axis_tready))
  `RPA_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> (!m_axis_tvalid && !s_axis_tready))

endmodule

`default_nettype wire
